// ===== sv/sac_pkg.sv =====
// Shared types, constants and helpers for the set-associative LRU cache tag array.
package sac_pkg;

	localparam int SET_CNT  = 256;
	localparam int WAYS     = 4;
	localparam int SET_W    = $clog2(SET_CNT);
	localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int RANK_W   = WAY_W;
	localparam int TAG_W    = 32;
	localparam int ADDR_W   = 32;
	localparam int CNT_W    = 32;
	localparam int CFG_W    = 4;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SHIFT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SET_SHIFT   = 1'b1;

	localparam logic [CFG_W-1:0] BLOCK_SHIFT_RST = 4'd5;
	localparam logic [CFG_W-1:0] SET_SHIFT_RST   = 4'd8;

	// One set as it lives in the tag RAM.
	typedef struct packed {
		logic [WAYS-1:0]             valid;
		logic [WAYS-1:0][RANK_W-1:0] rank;
		logic [WAYS-1:0][TAG_W-1:0]  tag;
	} row_t;

	localparam int ROW_W = $bits(row_t);

	// Outcome of one lookup.
	typedef struct packed {
		logic             hit;
		logic [WAY_W-1:0] way;
	} lookup_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
	endfunction

endpackage

// ===== sv/sac_if.sv =====
// Handshake channels for access words and result words.
interface sac_req_if;
	logic                      valid;
	logic                      ready;
	logic [sac_pkg::ADDR_W-1:0] addr;
	logic                      store_op;

	modport source (output valid, output addr, output store_op, input ready);
	modport sink   (input valid, input addr, input store_op, output ready);
endinterface

interface sac_rsp_if;
	logic                      valid;
	logic                      ready;
	logic                      hit;
	logic [1:0]                way;
	logic [sac_pkg::CNT_W-1:0] load_count;
	logic [sac_pkg::CNT_W-1:0] store_count;
	logic [sac_pkg::CNT_W-1:0] hit_total;
	logic [sac_pkg::CNT_W-1:0] miss_total;

	modport source (output valid, output hit, output way, output load_count,
		output store_count, output hit_total, output miss_total, input ready);
	modport sink   (input valid, input hit, input way, input load_count,
		input store_count, input hit_total, input miss_total, output ready);
endinterface

// ===== sv/set_assoc_lru_cache_tags.sv =====
// Top level of the set-associative LRU cache tag array with write-allocate.
//
//  Channel  Role   Word contents
//  -------  -----  ---------------------------------------------------------
//  req      sink   addr, store_op: one load or store access
//  rsp      source hit, way, load_count, store_count, hit_total, miss_total
//  cfg_*    write  cfg_index selects block offset width (0) or set index width (1)
//
// Each access first reads its set from the tag RAM, then does the compare,
// victim choice and write-back of the set. The next access is taken the
// cycle after the write-back, so back-to-back accesses to one set always
// read fresh data. Reset marks every set empty through one flag flip-flop
// per set; no clearing pass is needed and an access may follow reset at once.
// A result word waits in the output register; a stalled rsp holds the
// write-back of the following access until the register frees up.
module set_assoc_lru_cache_tags (
	input  logic                           clk,
	input  logic                           arst_n,
	sac_req_if.sink                        req,
	sac_rsp_if.source                      rsp,
	input  logic                           cfg_we,
	input  logic [sac_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sac_pkg::CFG_W-1:0]      cfg_data
);

	// Configuration registers.
	logic [sac_pkg::CFG_W-1:0] block_shift_q;
	logic [sac_pkg::CFG_W-1:0] set_shift_q;

	// Access held between the RAM read and the write-back.
	logic                        busy_q;
	logic [sac_pkg::SET_W-1:0]   set_s1;
	logic [sac_pkg::TAG_W-1:0]   tag_s1;
	logic                        store_s1;
	logic                        init_s1;

	// A set that was never written since reset reads as empty.
	logic [sac_pkg::SET_CNT-1:0] row_init_q;

	// Running counters; they double as the result payload since they only
	// move when the output register is free.
	logic [sac_pkg::CNT_W-1:0] loads_q;
	logic [sac_pkg::CNT_W-1:0] stores_q;
	logic [sac_pkg::CNT_W-1:0] hits_q;
	logic [sac_pkg::CNT_W-1:0] misses_q;

	logic                      rsp_valid_q;
	logic                      rsp_hit_q;
	logic [1:0]                rsp_way_q;

	logic                      accept;
	logic                      commit;
	logic [sac_pkg::ADDR_W-1:0] shifted;
	logic [sac_pkg::ADDR_W-1:0] index_mask;
	logic [sac_pkg::SET_W-1:0] set_in;
	logic [sac_pkg::TAG_W-1:0] tag_in;
	logic [4:0]                tag_shift;

	sac_pkg::row_t    rd_row;
	sac_pkg::row_t    cur_row;
	sac_pkg::row_t    new_row;
	sac_pkg::lookup_t lookup;

	assign req.ready = !busy_q;
	assign accept    = req.valid && !busy_q;
	assign commit    = busy_q && (!rsp_valid_q || rsp.ready);

	// Address split. Index bits beyond the set count simply alias.
	assign shifted    = req.addr >> block_shift_q;
	assign index_mask = (sac_pkg::ADDR_W'(1) << set_shift_q) - sac_pkg::ADDR_W'(1);
	assign set_in     = sac_pkg::SET_W'(shifted & index_mask);
	assign tag_shift  = 5'(block_shift_q) + 5'(set_shift_q);
	assign tag_in     = sac_pkg::TAG_W'(req.addr >> tag_shift);

	sac_ram #(
		.WIDTH (sac_pkg::ROW_W),
		.DEPTH (sac_pkg::SET_CNT)
	) u_tag_ram (
		.clk     (clk),
		.we      (commit),
		.wr_addr (set_s1),
		.wr_data (new_row),
		.re      (accept),
		.rd_addr (set_in),
		.rd_data (rd_row)
	);

	assign cur_row = init_s1 ? rd_row : '0;

	sac_replace u_replace (
		.row      (cur_row),
		.tag      (tag_s1),
		.result   (lookup),
		.row_next (new_row)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_shift_q <= sac_pkg::BLOCK_SHIFT_RST;
			set_shift_q   <= sac_pkg::SET_SHIFT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sac_pkg::REG_BLOCK_SHIFT: begin
					block_shift_q <= cfg_data;
				end
				sac_pkg::REG_SET_SHIFT: begin
					set_shift_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (commit) begin
			busy_q <= 1'b0;
		end
	end

	// Access payload; the set flag is sampled together with the RAM read.
	always_ff @(posedge clk) begin
		if (accept) begin
			set_s1   <= set_in;
			tag_s1   <= tag_in;
			store_s1 <= req.store_op;
			init_s1  <= row_init_q[set_in];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_init_q <= '0;
		end else if (commit) begin
			row_init_q[set_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loads_q  <= '0;
			stores_q <= '0;
			hits_q   <= '0;
			misses_q <= '0;
		end else if (commit) begin
			if (store_s1) begin
				stores_q <= sac_pkg::sat_inc(stores_q);
			end else begin
				loads_q <= sac_pkg::sat_inc(loads_q);
			end
			if (lookup.hit) begin
				hits_q <= sac_pkg::sat_inc(hits_q);
			end else begin
				misses_q <= sac_pkg::sat_inc(misses_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			rsp_hit_q <= lookup.hit;
			rsp_way_q <= 2'(lookup.way);
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.hit         = rsp_hit_q;
	assign rsp.way         = rsp_way_q;
	assign rsp.load_count  = loads_q;
	assign rsp.store_count = stores_q;
	assign rsp.hit_total   = hits_q;
	assign rsp.miss_total  = misses_q;

endmodule

// ===== sv/sac_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module sac_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (re) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== sv/sac_replace.sv =====
// Tag compare, victim choice and recency update for one set.
module sac_replace (
	input  sac_pkg::row_t                   row,
	input  logic [sac_pkg::TAG_W-1:0]       tag,
	output sac_pkg::lookup_t                result,
	output sac_pkg::row_t                   row_next
);

	always_comb begin
		logic                          hit;
		logic [sac_pkg::WAY_W-1:0]     hit_way;
		logic                          inv_found;
		logic [sac_pkg::WAY_W-1:0]     inv_way;
		logic [sac_pkg::RANK_W-1:0]    oldest;
		logic [sac_pkg::WAY_W-1:0]     lru_way;
		logic [sac_pkg::WAY_W-1:0]     victim;
		logic                          was_valid;
		logic [sac_pkg::RANK_W-1:0]    old_rank;

		hit       = 1'b0;
		hit_way   = '0;
		inv_found = 1'b0;
		inv_way   = '0;
		oldest    = '0;
		lru_way   = '0;
		for (int w = 0; w < sac_pkg::WAYS; w++) begin
			if (!hit && row.valid[w] && row.tag[w] == tag) begin
				hit     = 1'b1;
				hit_way = sac_pkg::WAY_W'(w);
			end
			if (!inv_found && !row.valid[w]) begin
				inv_found = 1'b1;
				inv_way   = sac_pkg::WAY_W'(w);
			end
			// Ties go to the higher way, matching a scan with >=.
			if (row.rank[w] >= oldest) begin
				oldest  = row.rank[w];
				lru_way = sac_pkg::WAY_W'(w);
			end
		end

		if (hit) begin
			victim = hit_way;
		end else if (inv_found) begin
			victim = inv_way;
		end else begin
			victim = lru_way;
		end

		was_valid = row.valid[victim];
		old_rank  = row.rank[victim];

		row_next = row;
		for (int k = 0; k < sac_pkg::WAYS; k++) begin
			if (sac_pkg::WAY_W'(k) == victim) begin
				row_next.rank[k]  = '0;
				row_next.valid[k] = 1'b1;
				row_next.tag[k]   = tag;
			end else if (row.valid[k] && (!was_valid || row.rank[k] < old_rank)) begin
				row_next.rank[k] = row.rank[k] + sac_pkg::RANK_W'(1);
			end
		end

		result.hit = hit;
		result.way = victim;
	end

endmodule
